@@ sv/sha256c_pkg.sv @@
`timescale 1ns / 1ps

package sha256c_pkg;

   localparam int WORD_W     = 32;
   localparam int NUM_WORDS  = 16;
   localparam int NUM_ROUNDS = 64;
   localparam int NUM_HASH   = 8;
   localparam int WCNT_W     = $clog2(NUM_WORDS);
   localparam int RCNT_W     = $clog2(NUM_ROUNDS);
   localparam int HIDX_W     = $clog2(NUM_HASH);
   localparam int CSR_ADDR_W = HIDX_W + 2;
   localparam int CSR_DATA_W = 32;

   typedef logic [WORD_W-1:0] word_type;
   typedef word_type hash_arr_type [NUM_HASH];

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FINAL,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic              shift_word;
      logic              reload;
      logic              load_vars;
      logic              round_en;
      logic [RCNT_W-1:0] round_idx;
      logic              add_chain;
      logic              emit_en;
      logic [HIDX_W-1:0] emit_idx;
   } dp_cmd_type;

   localparam word_type STD_IV [NUM_HASH] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam word_type ROUND_K [NUM_ROUNDS] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic word_type big_sig0(input word_type x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic word_type big_sig1(input word_type x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic word_type small_sig0(input word_type x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic word_type small_sig1(input word_type x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

endpackage

@@ sv/sha256c_ctrl.sv @@
`timescale 1ns / 1ps

module sha256c_ctrl
   import sha256c_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       req_new_message,
   output logic       busy,
   output dp_cmd_type cmd
);

   state_type         state_ff, state_in;
   logic [WCNT_W-1:0] wcnt_ff, wcnt_in;
   logic [RCNT_W-1:0] rcnt_ff, rcnt_in;
   logic [HIDX_W-1:0] ecnt_ff, ecnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wcnt_ff  <= '0;
         rcnt_ff  <= '0;
         ecnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         wcnt_ff  <= wcnt_in;
         rcnt_ff  <= rcnt_in;
         ecnt_ff  <= ecnt_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      wcnt_in       = wcnt_ff;
      rcnt_in       = rcnt_ff;
      ecnt_in       = ecnt_ff;
      busy          = 1'b1;
      cmd           = '0;
      cmd.round_idx = rcnt_ff;
      cmd.emit_idx  = ecnt_ff;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.shift_word = 1'b1;
               // the flag counts only on the first word of a block
               cmd.reload     = req_new_message && (wcnt_ff == '0);
               wcnt_in        = wcnt_ff + 1'b1;
               if (wcnt_ff == WCNT_W'(NUM_WORDS - 1)) begin
                  cmd.load_vars = 1'b1;
                  rcnt_in       = '0;
                  state_in      = ST_ROUND;
               end
            end
         end
         ST_ROUND: begin
            cmd.round_en = 1'b1;
            rcnt_in      = rcnt_ff + 1'b1;
            if (rcnt_ff == RCNT_W'(NUM_ROUNDS - 1)) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            cmd.add_chain = 1'b1;
            ecnt_in       = '0;
            state_in      = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.emit_en = 1'b1;
            ecnt_in     = ecnt_ff + 1'b1;
            if (ecnt_ff == HIDX_W'(NUM_HASH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ sv/sha256c_dp.sv @@
`timescale 1ns / 1ps

module sha256c_dp
   import sha256c_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  dp_cmd_type        cmd,
   input  word_type          req_message_word,
   input  hash_arr_type      init_h,
   output word_type          rsp_hash_word,
   output logic [HIDX_W-1:0] rsp_hash_index,
   output logic              rsp_last_word,
   output logic              rsp_strobe
);

   word_type          win_ff   [NUM_WORDS];
   word_type          var_ff   [NUM_HASH];
   word_type          chain_ff [NUM_HASH];
   word_type          word_ff;
   logic [HIDX_W-1:0] idx_ff;
   logic              last_ff;
   logic              strobe_ff;

   word_type w_next;
   word_type t1;
   word_type t2;
   word_type ch;
   word_type maj;

   // window holds W[t]..W[t+15]; W[t] feeds the current round
   assign w_next = small_sig1(win_ff[14]) + win_ff[9] + small_sig0(win_ff[1]) + win_ff[0];
   assign ch     = (var_ff[4] & var_ff[5]) ^ (~var_ff[4] & var_ff[6]);
   assign maj    = (var_ff[0] & var_ff[1]) ^ (var_ff[0] & var_ff[2]) ^ (var_ff[1] & var_ff[2]);
   assign t1     = var_ff[7] + big_sig1(var_ff[4]) + ch + ROUND_K[cmd.round_idx] + win_ff[0];
   assign t2     = big_sig0(var_ff[0]) + maj;

   always_ff @(posedge clock) begin
      if (cmd.shift_word || cmd.round_en) begin
         for (int i = 0; i < NUM_WORDS - 1; i++) begin
            win_ff[i] <= win_ff[i+1];
         end
         win_ff[NUM_WORDS-1] <= cmd.shift_word ? req_message_word : w_next;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_vars) begin
         for (int i = 0; i < NUM_HASH; i++) begin
            var_ff[i] <= chain_ff[i];
         end
      end else if (cmd.round_en) begin
         var_ff[7] <= var_ff[6];
         var_ff[6] <= var_ff[5];
         var_ff[5] <= var_ff[4];
         var_ff[4] <= var_ff[3] + t1;
         var_ff[3] <= var_ff[2];
         var_ff[2] <= var_ff[1];
         var_ff[1] <= var_ff[0];
         var_ff[0] <= t1 + t2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_HASH; i++) begin
            chain_ff[i] <= STD_IV[i];
         end
      end else if (cmd.reload) begin
         for (int i = 0; i < NUM_HASH; i++) begin
            chain_ff[i] <= init_h[i];
         end
      end else if (cmd.add_chain) begin
         for (int i = 0; i < NUM_HASH; i++) begin
            chain_ff[i] <= chain_ff[i] + var_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.emit_en;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_en) begin
         word_ff <= chain_ff[cmd.emit_idx];
         idx_ff  <= cmd.emit_idx;
         last_ff <= (cmd.emit_idx == HIDX_W'(NUM_HASH - 1));
      end
   end

   assign rsp_hash_word  = word_ff;
   assign rsp_hash_index = idx_ff;
   assign rsp_last_word  = last_ff;
   assign rsp_strobe     = strobe_ff;

endmodule

@@ sv/sha256_block_compress_top.sv @@
`timescale 1ns / 1ps

// SHA-256 block compression. Message words enter one per cycle while busy is
// low; on the sixteenth word of a block busy rises and one shared round unit
// runs the 64 rounds at one round per cycle, expanding the schedule alongside.
// Next the result is added into the chaining value; then the eight hash
// words leave on consecutive cycles, index 0 first, each marked by rsp_strobe
// for a single cycle, the last with rsp_last_word. The receiver cannot stall:
// it must take each word in the cycle it appears. A block is taken in as
// sixteen words; busy then stays high through the 64 rounds, the chain add
// and the eight emits, and no new word is accepted until busy falls.
// new_message on a block's first word reloads the chaining value from
// init_h0..init_h7 (APB, byte address 4*i, reset to the standard IV); write
// them only while busy is low and no block is half done.
module sha256_block_compress_top
   import sha256c_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [WORD_W-1:0]     req_message_word,
   input  logic                  req_new_message,
   output logic                  rsp_strobe,
   output logic [WORD_W-1:0]     rsp_hash_word,
   output logic [HIDX_W-1:0]     rsp_hash_index,
   output logic                  rsp_last_word,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   hash_arr_type      init_ff;
   dp_cmd_type        cmd;
   logic [HIDX_W-1:0] csr_idx;

   assign pready  = 1'b1;
   assign csr_idx = paddr[CSR_ADDR_W-1:2];
   assign prdata  = init_ff[csr_idx];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_HASH; i++) begin
            init_ff[i] <= STD_IV[i];
         end
      end else if (psel && penable && pwrite && pready) begin
         init_ff[csr_idx] <= pwdata;
      end
   end

   sha256c_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .req_new_message (req_new_message),
      .busy            (busy),
      .cmd             (cmd)
   );

   sha256c_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_message_word (req_message_word),
      .init_h           (init_ff),
      .rsp_hash_word    (rsp_hash_word),
      .rsp_hash_index   (rsp_hash_index),
      .rsp_last_word    (rsp_last_word),
      .rsp_strobe       (rsp_strobe)
   );

endmodule

@@ sv/sha256c_chk.sv @@
`timescale 1ns / 1ps

module sha256c_chk
   import sha256c_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              busy,
   input logic              rsp_strobe,
   input logic [HIDX_W-1:0] rsp_hash_index,
   input logic              rsp_last_word,
   input logic              pready
);

   // a run of hash words never breaks before its last word
   a_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last_word |=> rsp_strobe)
      else $error("hash word run broke before last word");

   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last_word |=> rsp_hash_index == $past(rsp_hash_index) + 1'b1)
      else $error("hash words out of order");

   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_last_word == (rsp_hash_index == HIDX_W'(NUM_HASH - 1))))
      else $error("last-word mark does not match index");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("hash word emitted outside a busy period");

   a_ready: assert property (@(posedge clock) disable iff (reset)
      pready)
      else $error("pready dropped");

endmodule

bind sha256_block_compress_top sha256c_chk u_chk (
   .clock          (clock),
   .reset          (reset),
   .busy           (busy),
   .rsp_strobe     (rsp_strobe),
   .rsp_hash_index (rsp_hash_index),
   .rsp_last_word  (rsp_last_word),
   .pready         (pready)
);
